@@ rtl/core/brb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = 11;
    localparam int LIM_W    = 7;
    localparam int QDEPTH   = 4;
    localparam int QA_W     = $clog2(QDEPTH);

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] WS_NONE   = 2'd0;
    localparam logic [1:0] WS_ACCEPT = 2'd1;
    localparam logic [1:0] WS_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic             first_of_block;
        logic [CNT_W-1:0] block_length;
        logic             last_of_block;
        logic [7:0]       write_byte;
        logic [LIM_W-1:0] read_limit;
    } brb_in_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             byte_valid;
        logic             last_result;
        logic [1:0]       write_status;
        logic [LIM_W-1:0] bytes_read;
        logic [CNT_W-1:0] fill_level;
        logic [CNT_W-1:0] free_space;
    } brb_out_t;

    typedef struct packed {
        logic             is_read;
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [1:0]       status;
        logic [PTR_W-1:0] rd_ptr;
        logic [LIM_W-1:0] rd_count;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] free;
    } brb_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RADDR,
        BK_RDATA
    } brb_bk_state_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] sum;
        sum = CNT_W'(p) + CNT_W'(1);
        return (sum >= cap) ? '0 : sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/brb_cmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brb_cmd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire brb_pkg::brb_cmd_t push_cmd,
    input  wire logic              pop,
    output brb_pkg::brb_cmd_t      head_cmd,
    output logic                   full,
    output logic                   empty
);
    import brb_pkg::*;

    brb_cmd_t          q_reg [QDEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QA_W:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == (QA_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = q_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QA_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QA_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QA_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QA_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/brb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brb_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [brb_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire logic                         accept,
    input  wire brb_pkg::brb_in_t             item,
    output logic                              push,
    output brb_pkg::brb_cmd_t                 cmd,
    output logic [brb_pkg::CNT_W-1:0]         capacity
);
    import brb_pkg::*;

    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] cwp_reg, cwp_next;
    logic [PTR_W-1:0] pwp_reg, pwp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             open_reg, open_next;
    logic             acc_reg, acc_next;
    logic [CNT_W-1:0] plen_reg, plen_next;
    logic [CNT_W-1:0] recv_reg, recv_next;

    logic [CNT_W-1:0] free_now;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] n;
    logic [CNT_W-1:0] rp_sum;

    assign capacity = cap_reg;
    assign free_now = cap_reg - count_reg;
    assign lim      = (item.read_limit > LIM_W'(MAX_READ)) ? LIM_W'(MAX_READ)
                                                           : item.read_limit;
    assign n        = (count_reg < CNT_W'(lim)) ? count_reg[LIM_W-1:0] : lim;
    assign rp_sum   = CNT_W'(rp_reg) + CNT_W'(n);

    always_comb
    begin
        cap_next   = cap_reg;
        rp_next    = rp_reg;
        cwp_next   = cwp_reg;
        pwp_next   = pwp_reg;
        count_next = count_reg;
        open_next  = open_reg;
        acc_next   = acc_reg;
        plen_next  = plen_reg;
        recv_next  = recv_reg;
        push       = 1'b0;
        cmd        = '0;

        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (cfg_wr_data > CNT_W'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = cfg_wr_data;
            end
            rp_next    = '0;
            cwp_next   = '0;
            pwp_next   = '0;
            count_next = '0;
            open_next  = 1'b0;
            acc_next   = 1'b0;
            plen_next  = '0;
            recv_next  = '0;
        end
        else if (accept)
        begin
            push       = 1'b1;
            cmd.status = WS_NONE;
            case (item.req_type)
                REQ_WRITE:
                begin
                    // first byte judges the block
                    if (item.first_of_block)
                    begin
                        pwp_next  = cwp_reg;
                        recv_next = '0;
                        open_next = 1'b1;
                        if (item.block_length != '0 && item.block_length <= free_now)
                        begin
                            acc_next   = 1'b1;
                            plen_next  = item.block_length;
                            cmd.status = WS_ACCEPT;
                        end
                        else
                        begin
                            acc_next   = 1'b0;
                            plen_next  = '0;
                            cmd.status = WS_REJECT;
                        end
                    end
                    if (open_next && acc_next && plen_next != '0)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = pwp_next;
                        cmd.wr_data = item.write_byte;
                        pwp_next    = next_ptr(pwp_next, cap_reg);
                        plen_next   = plen_next - CNT_W'(1);
                        recv_next   = recv_next + CNT_W'(1);
                    end
                    // last byte commits what arrived
                    if (item.last_of_block && open_next)
                    begin
                        if (acc_next)
                        begin
                            cwp_next   = pwp_next;
                            count_next = count_reg + recv_next;
                        end
                        open_next = 1'b0;
                        acc_next  = 1'b0;
                        plen_next = '0;
                        recv_next = '0;
                    end
                end
                REQ_READ:
                begin
                    cmd.is_read  = 1'b1;
                    cmd.rd_ptr   = rp_reg;
                    cmd.rd_count = n;
                    rp_next      = (rp_sum >= cap_reg) ? PTR_W'(rp_sum - cap_reg)
                                                       : rp_sum[PTR_W-1:0];
                    count_next   = count_reg - CNT_W'(n);
                end
                REQ_CLEAR:
                begin
                    rp_next    = '0;
                    cwp_next   = '0;
                    pwp_next   = '0;
                    count_next = '0;
                    open_next  = 1'b0;
                    acc_next   = 1'b0;
                    plen_next  = '0;
                    recv_next  = '0;
                end
                default:
                begin
                end
            endcase
            cmd.fill = count_next;
            cmd.free = cap_reg - count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            rp_reg    <= '0;
            cwp_reg   <= '0;
            pwp_reg   <= '0;
            count_reg <= '0;
            open_reg  <= 1'b0;
            acc_reg   <= 1'b0;
            plen_reg  <= '0;
            recv_reg  <= '0;
        end
        else
        begin
            cap_reg   <= cap_next;
            rp_reg    <= rp_next;
            cwp_reg   <= cwp_next;
            pwp_reg   <= pwp_next;
            count_reg <= count_next;
            open_reg  <= open_next;
            acc_reg   <= acc_next;
            plen_reg  <= plen_next;
            recv_reg  <= recv_next;
        end
    end

    a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("stored count exceeds capacity");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg != '0 && cap_reg <= CNT_W'(DEPTH))
        else $error("capacity out of range");

    a_ptrs_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(rp_reg) < cap_reg && CNT_W'(cwp_reg) < cap_reg)
        else $error("pointer beyond capacity");

    a_block_space: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg && acc_reg) |-> (recv_reg + plen_reg <= cap_reg - count_reg))
        else $error("open block overruns free space");

endmodule

`default_nettype wire

@@ rtl/core/brb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brb_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [brb_pkg::CNT_W-1:0] capacity,
    input  wire brb_pkg::brb_cmd_t         head_cmd,
    input  wire logic                      empty,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output brb_pkg::brb_out_t              out_data
);
    import brb_pkg::*;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rdata_reg;

    brb_bk_state_t    state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [LIM_W-1:0] left_reg, left_next;
    logic [LIM_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic             out_valid_reg, out_valid_next;
    brb_out_t         out_reg, out_next;

    logic             out_free;
    logic             mem_we;
    logic             mem_re;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        total_next     = total_reg;
        fill_next      = fill_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    if (head_cmd.is_read && head_cmd.rd_count != '0)
                    begin
                        pop        = 1'b1;
                        ptr_next   = head_cmd.rd_ptr;
                        left_next  = head_cmd.rd_count;
                        total_next = head_cmd.rd_count;
                        fill_next  = head_cmd.fill;
                        free_next  = head_cmd.free;
                        state_next = BK_RADDR;
                    end
                    else if (out_free)
                    begin
                        pop                   = 1'b1;
                        mem_we                = head_cmd.wr_en;
                        out_valid_next        = 1'b1;
                        out_next              = '0;
                        out_next.last_result  = 1'b1;
                        out_next.write_status = head_cmd.status;
                        out_next.fill_level   = head_cmd.fill;
                        out_next.free_space   = head_cmd.free;
                    end
                end
            end
            BK_RADDR:
            begin
                mem_re     = 1'b1;
                state_next = BK_RDATA;
            end
            BK_RDATA:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.read_byte    = rdata_reg;
                    out_next.byte_valid   = 1'b1;
                    out_next.last_result  = (left_reg == LIM_W'(1));
                    out_next.write_status = WS_NONE;
                    out_next.bytes_read   = (left_reg == LIM_W'(1)) ? total_reg : '0;
                    out_next.fill_level   = fill_reg;
                    out_next.free_space   = free_reg;
                    ptr_next              = next_ptr(ptr_reg, capacity);
                    left_next             = left_reg - LIM_W'(1);
                    state_next            = (left_reg == LIM_W'(1)) ? BK_IDLE : BK_RADDR;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head_cmd.wr_addr] <= head_cmd.wr_data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        total_reg <= total_next;
        fill_reg  <= fill_next;
        free_reg  <= free_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RADDR || state_reg == BK_RDATA) |-> left_reg != '0)
        else $error("read burst with no bytes left");

    a_no_pop_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !pop)
        else $error("queue popped during read burst");

    a_rdata_follows_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RDATA) |-> $past(state_reg == BK_RADDR)
                                     || $past(state_reg == BK_RDATA))
        else $error("data phase without address phase");

endmodule

`default_nettype wire

@@ rtl/core/byte_ring_buffer_block_write_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte ring buffer taking whole write blocks or nothing. Every input transfer
// yields one result, except a read of n > 0 bytes, which yields one result per
// byte returned (up to 64). A front stage does all pointer and fill bookkeeping
// and takes one transfer per cycle while its four-entry command queue has room;
// a back stage owns the 1024-byte store and drains the queue. It retires write,
// clear and empty-read commands from idle once the output register is free; a
// read steps through an address and a data state per byte, as the registered
// read port of the store feeds the output register. Writing capacity (clamped
// to 1..1024) empties the buffer; the user must do so only while the block is idle (not enforced).
module byte_ring_buffer_block_write_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [brb_pkg::CNT_W-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire brb_pkg::brb_in_t          in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output brb_pkg::brb_out_t              out_data
);
    import brb_pkg::*;

    logic             push;
    brb_cmd_t         push_cmd;
    brb_cmd_t         head_cmd;
    logic             pop;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] capacity;

    assign in_ready = !full;

    brb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (in_valid && in_ready),
        .item        (in_data),
        .push        (push),
        .cmd         (push_cmd),
        .capacity    (capacity)
    );

    brb_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (full),
        .empty    (empty)
    );

    brb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity),
        .head_cmd  (head_cmd),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
